// ===== hdl/rational_accumulate_alu_core_assert.svh =====
// Assertion macros shared by the rational accumulator RTL.
`ifndef RATIONAL_ACCUMULATE_ALU_CORE_ASSERT_SVH
`define RATIONAL_ACCUMULATE_ALU_CORE_ASSERT_SVH

// Condition holds at every edge out of reset.
`define RAC_ASSERT_HOLDS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("rational accumulator check failed");

// Consequent holds in the same cycle as the antecedent.
`define RAC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rational accumulator check failed");

// Consequent holds in the cycle after the antecedent.
`define RAC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rational accumulator check failed");

`endif

// ===== hdl/rac_pkg.sv =====
package rac_pkg;

    localparam int OPD_W     = 32;
    localparam int PROD_W    = 64;
    localparam int MAG_W     = 63;
    localparam int DEN_W     = 31;
    localparam int OP_W      = 2;
    localparam int STS_W     = 2;
    localparam int WIDTH_DEF = 32;

    localparam logic [STS_W-1:0] STS_OK       = 2'd0;
    localparam logic [STS_W-1:0] STS_ZERO_DEN = 2'd1;
    localparam logic [STS_W-1:0] STS_DIV_ZERO = 2'd2;
    localparam logic [STS_W-1:0] STS_OVERFLOW = 2'd3;

    localparam logic [OP_W-1:0] OP_ADD = 2'd0;
    localparam logic [OP_W-1:0] OP_SUB = 2'd1;
    localparam logic [OP_W-1:0] OP_MUL = 2'd2;
    localparam logic [OP_W-1:0] OP_DIV = 2'd3;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_APPLY = 1'b1;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_sts;

endpackage

// ===== hdl/rac_channels.sv =====
interface rac_item_if;
    logic                              valid;
    logic                              ready;
    logic                              kind;
    logic [rac_pkg::OP_W-1:0]          op;
    logic signed [rac_pkg::OPD_W-1:0]  operand_num;
    logic signed [rac_pkg::OPD_W-1:0]  operand_den;

    modport source (output valid, kind, op, operand_num, operand_den, input ready);
    modport sink   (input valid, kind, op, operand_num, operand_den, output ready);
endinterface

interface rac_result_if;
    logic                              valid;
    logic                              ready;
    logic signed [rac_pkg::OPD_W-1:0]  result_num;
    logic [rac_pkg::DEN_W-1:0]         result_den;
    logic [rac_pkg::STS_W-1:0]         status;

    modport source (output valid, result_num, result_den, status, input ready);
    modport sink   (input valid, result_num, result_den, status, output ready);
endinterface

// ===== hdl/rac_gcd.sv =====
module rac_gcd #(
    parameter int DW = rac_pkg::MAG_W
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [DW-1:0]      i_a,
    input  logic [DW-1:0]      i_b,
    output logic [DW-1:0]      o_gcd,
    output rac_pkg::t_unit_sts o_sts
);

    localparam int KW = $clog2(DW);

    logic [DW-1:0] r_a;
    logic [DW-1:0] r_b;
    logic [KW-1:0] r_k;
    logic          r_busy;
    logic          r_done;
    logic [DW-1:0] w_diff;

    assign w_diff = (r_a > r_b) ? (r_a - r_b) : (r_b - r_a);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_a    <= i_a;
                r_b    <= i_b;
                r_k    <= '0;
            end else if (r_busy) begin
                if (r_a == r_b) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else if (!r_a[0] && !r_b[0]) begin
                    r_a <= r_a >> 1;
                    r_b <= r_b >> 1;
                    r_k <= r_k + KW'(1);
                end else if (!r_a[0]) begin
                    r_a <= r_a >> 1;
                end else if (!r_b[0]) begin
                    r_b <= r_b >> 1;
                end else if (r_a > r_b) begin
                    r_a <= w_diff >> 1;
                end else begin
                    r_b <= w_diff >> 1;
                end
            end
        end
    end

    assign o_gcd      = r_a << r_k;
    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;

endmodule

// ===== hdl/rac_div.sv =====
module rac_div #(
    parameter int DW = rac_pkg::MAG_W
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [DW-1:0]      i_dividend,
    input  logic [DW-1:0]      i_divisor,
    output logic [DW-1:0]      o_quot,
    output rac_pkg::t_unit_sts o_sts
);

    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_quo;
    logic [DW-1:0] r_div;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [DW:0]   w_trial;
    logic [DW:0]   w_sub;
    logic          w_ge;

    assign w_trial = {r_rem, r_quo[DW-1]};
    assign w_sub   = w_trial - {1'b0, r_div};
    assign w_ge    = !w_sub[DW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_rem  <= '0;
                r_quo  <= i_dividend;
                r_div  <= i_divisor;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_rem <= w_ge ? w_sub[DW-1:0] : w_trial[DW-1:0];
                r_quo <= {r_quo[DW-2:0], w_ge};
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == CW'(DW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_quot     = r_quo;
    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;

endmodule

// ===== hdl/rational_accumulate_alu_core.sv =====
// Channel   Dir  Beat payload
// i_item    in   kind, op, operand_num, operand_den
// o_result  out  result_num, result_den, status
//
// One beat in, one beat out. A load runs the sum, the binary gcd walk and two divisions;
// apply adds three multiply steps first, and a zero result skips the gcd and the divisions.
// The 63-bit restoring divider gives one quotient for the numerator and one for the denominator.
// Error beats skip the arithmetic and go straight to the done state.
// Reset is synchronous, active low, and leaves the accumulator at 0/1.
// i_item.ready is high only while the sequencer is idle; a finished beat waits in the
// result register, and the next item is taken while it waits.
`include "rational_accumulate_alu_core_assert.svh"

module rational_accumulate_alu_core #(
    parameter int WIDTH = rac_pkg::WIDTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rac_item_if.sink      i_item,
    rac_result_if.source  o_result
);

    localparam int OPD_W  = rac_pkg::OPD_W;
    localparam int PROD_W = rac_pkg::PROD_W;
    localparam int MAG_W  = rac_pkg::MAG_W;
    localparam int DEN_W  = rac_pkg::DEN_W;
    localparam int STS_W  = rac_pkg::STS_W;
    localparam int OP_W   = rac_pkg::OP_W;

    localparam logic [MAG_W-1:0] LIM = MAG_W'(1) << (WIDTH - 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_SUM  = 3'd2;
    localparam logic [2:0] S_GCD  = 3'd3;
    localparam logic [2:0] S_DIVN = 3'd4;
    localparam logic [2:0] S_DIVD = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0]               r_state;
    logic [2:0]               n_state;
    logic                     r_kind;
    logic [OP_W-1:0]          r_op;
    logic signed [OPD_W-1:0]  r_rn;
    logic signed [OPD_W-1:0]  r_rd;
    logic [1:0]               r_step;
    logic signed [PROD_W-1:0] r_x;
    logic signed [PROD_W-1:0] r_y;
    logic signed [PROD_W-1:0] r_z;
    logic [MAG_W-1:0]         r_mn;
    logic [MAG_W-1:0]         r_md;
    logic                     r_neg;
    logic [STS_W-1:0]         r_status;
    logic                     r_kick;
    logic                     r_out_valid;
    logic [STS_W-1:0]         r_out_status;
    logic signed [WIDTH-1:0]  r_acc_num;
    logic [WIDTH-2:0]         r_acc_den;

    logic                     w_accept;
    logic                     w_emit;
    logic signed [OPD_W-1:0]  w_acc_num_x;
    logic signed [OPD_W-1:0]  w_acc_den_x;
    logic signed [OPD_W-1:0]  w_mul_a;
    logic signed [OPD_W-1:0]  w_mul_b;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [PROD_W-1:0] w_n;
    logic signed [PROD_W-1:0] w_d;
    logic [MAG_W-1:0]         w_mn;
    logic [MAG_W-1:0]         w_md;
    logic                     w_ovf;
    logic [STS_W-1:0]         w_final;
    logic [MAG_W-1:0]         w_g;
    logic [MAG_W-1:0]         w_q;
    rac_pkg::t_unit_sts       w_gcd_sts;
    rac_pkg::t_unit_sts       w_div_sts;

    assign i_item.ready = (r_state == S_IDLE);
    assign w_accept     = i_item.valid && i_item.ready;
    assign w_emit       = (r_state == S_DONE) && (!r_out_valid || o_result.ready);

    assign w_acc_num_x = OPD_W'(r_acc_num);
    assign w_acc_den_x = OPD_W'(r_acc_den);

    // Shared multiplier: one product per cycle over three steps.
    always_comb begin
        w_mul_a = (r_step == 2'd0) ? w_acc_num_x : w_acc_den_x;
        case (r_step)
            2'd0:    w_mul_b = (r_op == rac_pkg::OP_MUL) ? r_rn : r_rd;
            2'd1:    w_mul_b = r_rn;
            default: w_mul_b = r_rd;
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;

    always_comb begin
        if (r_kind == rac_pkg::KIND_LOAD) begin
            w_n = PROD_W'(r_rn);
            w_d = PROD_W'(r_rd);
        end else begin
            case (r_op)
                rac_pkg::OP_ADD: begin
                    w_n = r_x + r_y;
                    w_d = r_z;
                end
                rac_pkg::OP_SUB: begin
                    w_n = r_x - r_y;
                    w_d = r_z;
                end
                rac_pkg::OP_MUL: begin
                    w_n = r_x;
                    w_d = r_z;
                end
                default: begin
                    w_n = r_x;
                    w_d = r_y;
                end
            endcase
        end
    end

    assign w_mn = MAG_W'(w_n[PROD_W-1] ? -w_n : w_n);
    assign w_md = MAG_W'(w_d[PROD_W-1] ? -w_d : w_d);

    assign w_ovf   = (r_md > LIM - MAG_W'(1)) ||
                     (r_neg ? (r_mn > LIM) : (r_mn > LIM - MAG_W'(1)));
    assign w_final = (r_status != rac_pkg::STS_OK) ? r_status :
                     (w_ovf ? rac_pkg::STS_OVERFLOW : rac_pkg::STS_OK);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_item.operand_den == '0) begin
                        n_state = S_DONE;
                    end else if (i_item.kind == rac_pkg::KIND_APPLY &&
                                 i_item.op == rac_pkg::OP_DIV &&
                                 i_item.operand_num == '0) begin
                        n_state = S_DONE;
                    end else if (i_item.kind == rac_pkg::KIND_LOAD) begin
                        n_state = S_SUM;
                    end else begin
                        n_state = S_MUL;
                    end
                end
            end
            S_MUL: begin
                if (r_step == 2'd2) begin
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                n_state = (w_mn == '0) ? S_DONE : S_GCD;
            end
            S_GCD: begin
                if (w_gcd_sts.done) begin
                    n_state = S_DIVN;
                end
            end
            S_DIVN: begin
                if (w_div_sts.done) begin
                    n_state = S_DIVD;
                end
            end
            S_DIVD: begin
                if (w_div_sts.done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_emit) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_kick      <= 1'b0;
            r_out_valid <= 1'b0;
            r_acc_num   <= '0;
            r_acc_den   <= (WIDTH-1)'(1);
        end else begin
            r_state <= n_state;
            r_kick  <= (n_state != r_state) &&
                       (n_state == S_GCD || n_state == S_DIVN || n_state == S_DIVD);

            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end

            // Commit the reduced fraction together with its result beat.
            if (w_emit && w_final == rac_pkg::STS_OK) begin
                r_acc_num <= WIDTH'(r_neg ? (MAG_W'(0) - r_mn) : r_mn);
                r_acc_den <= (WIDTH-1)'(r_md);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind <= i_item.kind;
            r_op   <= i_item.op;
            r_rn   <= i_item.operand_num;
            r_rd   <= i_item.operand_den;
            r_step <= 2'd0;
            if (i_item.operand_den == '0) begin
                r_status <= rac_pkg::STS_ZERO_DEN;
            end else if (i_item.kind == rac_pkg::KIND_APPLY &&
                         i_item.op == rac_pkg::OP_DIV &&
                         i_item.operand_num == '0) begin
                r_status <= rac_pkg::STS_DIV_ZERO;
            end else begin
                r_status <= rac_pkg::STS_OK;
            end
        end

        if (r_state == S_MUL) begin
            case (r_step)
                2'd0:    r_x <= w_prod;
                2'd1:    r_y <= w_prod;
                default: r_z <= w_prod;
            endcase
            r_step <= r_step + 2'd1;
        end

        if (r_state == S_SUM) begin
            if (w_mn == '0) begin
                r_mn  <= '0;
                r_md  <= MAG_W'(1);
                r_neg <= 1'b0;
            end else begin
                r_mn  <= w_mn;
                r_md  <= w_md;
                r_neg <= w_n[PROD_W-1] ^ w_d[PROD_W-1];
            end
        end

        if (r_state == S_DIVN && w_div_sts.done) begin
            r_mn <= w_q;
        end
        if (r_state == S_DIVD && w_div_sts.done) begin
            r_md <= w_q;
        end

        if (w_emit) begin
            r_out_status <= w_final;
        end
    end

    rac_gcd #(
        .DW (MAG_W)
    ) u_gcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_kick && r_state == S_GCD),
        .i_a     (r_mn),
        .i_b     (r_md),
        .o_gcd   (w_g),
        .o_sts   (w_gcd_sts)
    );

    rac_div #(
        .DW (MAG_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_kick && (r_state == S_DIVN || r_state == S_DIVD)),
        .i_dividend ((r_state == S_DIVN) ? r_mn : r_md),
        .i_divisor  (w_g),
        .o_quot     (w_q),
        .o_sts      (w_div_sts)
    );

    assign o_result.valid      = r_out_valid;
    assign o_result.result_num = OPD_W'(r_acc_num);
    assign o_result.result_den = DEN_W'(r_acc_den);
    assign o_result.status     = r_out_status;

    `RAC_ASSERT_HOLDS(a_den_nonzero, i_clk, i_rst_n, r_acc_den != '0)
    `RAC_ASSERT_IMPLIES(a_zero_canon, i_clk, i_rst_n, r_acc_num == '0, r_acc_den == (WIDTH-1)'(1))
    `RAC_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, w_accept, !i_item.ready)
    `RAC_ASSERT_IMPLIES(a_gcd_done_state, i_clk, i_rst_n, w_gcd_sts.done, r_state == S_GCD)
    `RAC_ASSERT_IMPLIES(a_div_done_state, i_clk, i_rst_n, w_div_sts.done, r_state == S_DIVN || r_state == S_DIVD)

endmodule

// ===== sim/rational_accumulate_alu_core_checker.sv =====
module rational_accumulate_alu_core_checker #(
    parameter int WIDTH = rac_pkg::WIDTH_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    rac_item_if    i_item,
    rac_result_if  i_result,
    output int     o_errors,
    output int     o_pending
);

    localparam int OPD_W     = rac_pkg::OPD_W;
    localparam int DEN_W     = rac_pkg::DEN_W;
    localparam int STS_W     = rac_pkg::STS_W;
    localparam int OP_W      = rac_pkg::OP_W;
    localparam int PRINT_CAP = 40;

    typedef struct {
        logic signed [OPD_W-1:0] num;
        logic [DEN_W-1:0]        den;
        logic [STS_W-1:0]        status;
    } t_fraction_beat;

    longint         acc_num = 0;
    longint         acc_den = 1;
    t_fraction_beat expected_q[$];
    t_fraction_beat want_beat;
    int             error_count = 0;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        error_count++;
        if (error_count <= PRINT_CAP) begin
            $display("mismatch on %s at %0t: got %0d, expected %0d", what, $time, got, want);
        end
    endtask

    function automatic longint unsigned magnitude_of(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    // Reduce n/d to lowest terms and commit it to the accumulator if it fits.
    function automatic logic [STS_W-1:0] reduce_into_acc(input longint n, input longint d);
        longint unsigned mn;
        longint unsigned md;
        longint unsigned a;
        longint unsigned b;
        longint unsigned t;
        longint unsigned lim;
        logic            neg;
        mn  = magnitude_of(n);
        md  = magnitude_of(d);
        neg = (n < 0) != (d < 0);
        lim = 64'd1 << (WIDTH - 1);
        if (md == 0) begin
            return rac_pkg::STS_ZERO_DEN;
        end
        if (mn == 0) begin
            md  = 1;
            neg = 1'b0;
        end else begin
            a = mn;
            b = md;
            while (b != 0) begin
                t = a % b;
                a = b;
                b = t;
            end
            mn = mn / a;
            md = md / a;
        end
        if (md > lim - 1) begin
            return rac_pkg::STS_OVERFLOW;
        end
        if (neg ? (mn > lim) : (mn > lim - 1)) begin
            return rac_pkg::STS_OVERFLOW;
        end
        acc_num = neg ? -longint'(mn) : longint'(mn);
        acc_den = longint'(md);
        return rac_pkg::STS_OK;
    endfunction

    function automatic t_fraction_beat fold_fraction(input logic kind,
                                                     input logic [OP_W-1:0] op,
                                                     input logic signed [OPD_W-1:0] num_in,
                                                     input logic signed [OPD_W-1:0] den_in);
        longint         rn;
        longint         rd;
        t_fraction_beat beat;
        rn = num_in;
        rd = den_in;
        if (rd == 0) begin
            beat.status = rac_pkg::STS_ZERO_DEN;
        end else if (kind == rac_pkg::KIND_LOAD) begin
            beat.status = reduce_into_acc(rn, rd);
        end else begin
            case (op)
                rac_pkg::OP_ADD: begin
                    beat.status = reduce_into_acc(acc_num * rd + acc_den * rn, acc_den * rd);
                end
                rac_pkg::OP_SUB: begin
                    beat.status = reduce_into_acc(acc_num * rd - acc_den * rn, acc_den * rd);
                end
                rac_pkg::OP_MUL: begin
                    beat.status = reduce_into_acc(acc_num * rn, acc_den * rd);
                end
                default: begin
                    if (rn == 0) begin
                        beat.status = rac_pkg::STS_DIV_ZERO;
                    end else begin
                        beat.status = reduce_into_acc(acc_num * rd, acc_den * rn);
                    end
                end
            endcase
        end
        beat.num = acc_num[OPD_W-1:0];
        beat.den = acc_den[DEN_W-1:0];
        return beat;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            acc_num = 0;
            acc_den = 1;
            expected_q.delete();
        end else begin
            if (i_result.valid && i_result.ready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected result beat", i_result.result_num, 0);
                end else begin
                    want_beat = expected_q[0];
                    expected_q.delete(0);
                    if (i_result.result_num !== want_beat.num) begin
                        report_mismatch("result_num", i_result.result_num, want_beat.num);
                    end
                    if (i_result.result_den !== want_beat.den) begin
                        report_mismatch("result_den", i_result.result_den, want_beat.den);
                    end
                    if (i_result.status !== want_beat.status) begin
                        report_mismatch("status", i_result.status, want_beat.status);
                    end
                end
            end
            if (i_item.valid && i_item.ready) begin
                expected_q.insert(expected_q.size(),
                                  fold_fraction(i_item.kind, i_item.op,
                                                i_item.operand_num, i_item.operand_den));
            end
        end
        o_errors  <= error_count;
        o_pending <= expected_q.size();
    end

endmodule

// ===== sim/rational_accumulate_alu_core_tb.sv =====
module rational_accumulate_alu_core_tb;

    localparam int WIDTH        = rac_pkg::WIDTH_DEF;
    localparam int OPD_W        = rac_pkg::OPD_W;
    localparam int OP_W         = rac_pkg::OP_W;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_WAIT   = 400;
    localparam int RANDOM_BEATS = 550;
    localparam int QUIET_TAIL   = 60;

    localparam logic signed [OPD_W-1:0] MOST_NEG = 32'sh8000_0000;
    localparam logic signed [OPD_W-1:0] MOST_POS = 32'sh7fff_ffff;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic quiet       = 1'b0;
    int   idle_pct    = 0;
    int   stall_left  = 0;
    int   cycle_count = 0;
    int   errors;
    int   pending;

    rac_item_if   item_ch();
    rac_result_if result_ch();

    rational_accumulate_alu_core #(.WIDTH(WIDTH)) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (result_ch)
    );

    rational_accumulate_alu_core_checker #(.WIDTH(WIDTH)) u_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (item_ch),
        .i_result  (result_ch),
        .o_errors  (errors),
        .o_pending (pending)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Stall the result side in bursts.
    always @(negedge i_clk) begin
        if (stall_left > 0 && !quiet) begin
            stall_left--;
            result_ch.ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 99) < idle_pct) begin
            stall_left = $urandom_range(0, 6);
            result_ch.ready <= 1'b0;
        end else begin
            result_ch.ready <= 1'b1;
        end
    end

    function automatic logic signed [OPD_W-1:0] pick_operand();
        logic [31:0] r;
        r = $urandom();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom_range(0, 40) - 20;
            4, 5:       return {{16{r[15]}}, r[15:0]};
            6, 7:       return r;
            default: begin
                case (r[1:0])
                    2'd0:    return MOST_NEG;
                    2'd1:    return MOST_POS;
                    2'd2:    return 1;
                    default: return -1;
                endcase
            end
        endcase
    endfunction

    // Call at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_fraction(input logic kind, input logic [OP_W-1:0] op,
                                 input logic signed [OPD_W-1:0] num,
                                 input logic signed [OPD_W-1:0] den);
        if (!quiet && $urandom_range(0, 99) < idle_pct) begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
        item_ch.valid       <= 1'b1;
        item_ch.kind        <= kind;
        item_ch.op          <= op;
        item_ch.operand_num <= num;
        item_ch.operand_den <= den;
        do @(posedge i_clk); while (item_ch.ready !== 1'b1);
        @(negedge i_clk);
    endtask

    initial begin
        logic                    rk;
        logic [OP_W-1:0]         rop;
        logic signed [OPD_W-1:0] rnum;
        logic signed [OPD_W-1:0] rden;

        item_ch.valid       = 1'b0;
        item_ch.kind        = rac_pkg::KIND_LOAD;
        item_ch.op          = rac_pkg::OP_ADD;
        item_ch.operand_num = '0;
        item_ch.operand_den = 32'sd1;
        result_ch.ready     = 1'b0;

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n  <= 1'b1;
        idle_pct  = 20;

        send_fraction(rac_pkg::KIND_LOAD,  rac_pkg::OP_DIV, 0, 5);
        send_fraction(rac_pkg::KIND_LOAD,  rac_pkg::OP_ADD, 3, 4);
        send_fraction(rac_pkg::KIND_APPLY, rac_pkg::OP_ADD, 1, 4);
        send_fraction(rac_pkg::KIND_APPLY, rac_pkg::OP_SUB, 5, -3);
        send_fraction(rac_pkg::KIND_APPLY, rac_pkg::OP_MUL, -7, 9);
        send_fraction(rac_pkg::KIND_APPLY, rac_pkg::OP_DIV, 2, -3);
        send_fraction(rac_pkg::KIND_APPLY, rac_pkg::OP_DIV, 0, 5);
        send_fraction(rac_pkg::KIND_APPLY, rac_pkg::OP_ADD, 3, 0);
        send_fraction(rac_pkg::KIND_LOAD,  rac_pkg::OP_ADD, 1, 0);
        send_fraction(rac_pkg::KIND_APPLY, rac_pkg::OP_DIV, 0, 0);
        send_fraction(rac_pkg::KIND_LOAD,  rac_pkg::OP_ADD, MOST_NEG, 1);
        send_fraction(rac_pkg::KIND_LOAD,  rac_pkg::OP_ADD, MOST_NEG, -1);
        send_fraction(rac_pkg::KIND_LOAD,  rac_pkg::OP_ADD, 1, MOST_NEG);
        send_fraction(rac_pkg::KIND_LOAD,  rac_pkg::OP_ADD, MOST_NEG, MOST_NEG);
        send_fraction(rac_pkg::KIND_LOAD,  rac_pkg::OP_SUB, 6, -4);
        send_fraction(rac_pkg::KIND_LOAD,  rac_pkg::OP_ADD, MOST_POS, 1);
        send_fraction(rac_pkg::KIND_APPLY, rac_pkg::OP_MUL, 2, 1);
        send_fraction(rac_pkg::KIND_APPLY, rac_pkg::OP_ADD, MOST_POS, MOST_POS);
        send_fraction(rac_pkg::KIND_APPLY, rac_pkg::OP_SUB, MOST_POS, 1);
        send_fraction(rac_pkg::KIND_LOAD,  rac_pkg::OP_ADD, 1, MOST_POS);
        send_fraction(rac_pkg::KIND_APPLY, rac_pkg::OP_MUL, 1, 2);
        send_fraction(rac_pkg::KIND_APPLY, rac_pkg::OP_DIV, MOST_NEG, MOST_POS);
        send_fraction(rac_pkg::KIND_APPLY, rac_pkg::OP_MUL, 0, MOST_NEG);
        send_fraction(rac_pkg::KIND_APPLY, rac_pkg::OP_SUB, MOST_NEG, MOST_POS);
        send_fraction(rac_pkg::KIND_APPLY, rac_pkg::OP_ADD, MOST_NEG, MOST_POS);

        for (int n = 0; n < RANDOM_BEATS; n++) begin
            if (n % 32 == 0) begin
                case ($urandom_range(0, 2))
                    0:       idle_pct = 0;
                    1:       idle_pct = 20;
                    default: idle_pct = 50;
                endcase
            end
            quiet = (n >= RANDOM_BEATS - QUIET_TAIL);
            rk    = ($urandom_range(0, 4) == 0) ? rac_pkg::KIND_LOAD : rac_pkg::KIND_APPLY;
            rop   = OP_W'($urandom_range(0, 3));
            rnum  = pick_operand();
            rden  = pick_operand();
            if ($urandom_range(0, 19) == 0) begin
                rden = '0;
            end
            if (rop == rac_pkg::OP_DIV && $urandom_range(0, 7) == 0) begin
                rnum = '0;
            end
            send_fraction(rk, rop, rnum, rden);
        end
        item_ch.valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
